### hdl/ryuv_pkg.sv
package ryuv_pkg;

	localparam int DEFAULT_MAX_DIM = 4096;

	localparam int PIX_W      = 8;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	// bt.601 studio range coefficients, scaled by 256
	localparam int COEF_Y_R  = 66;
	localparam int COEF_Y_G  = 129;
	localparam int COEF_Y_B  = 25;
	localparam int COEF_CB_R = 38;
	localparam int COEF_CB_G = 74;
	localparam int COEF_CB_B = 112;
	localparam int COEF_CR_R = 112;
	localparam int COEF_CR_G = 94;
	localparam int COEF_CR_B = 18;
	localparam int ROUND_BIAS = 128;
	localparam int LUMA_OFFSET = 16;
	// rounding bias plus a lift that keeps the difference non-negative
	localparam int CHROMA_BIAS = 128 + 32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CK_NONE = 2'd0,
		CK_CB   = 2'd1,
		CK_CR   = 2'd2
	} chroma_kind_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] chroma;
		chroma_kind_t     chroma_kind;
		logic             frame_end;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_word_t;

	typedef struct packed {
		chroma_kind_t chroma_kind;
		logic         frame_end;
	} pos_t;

endpackage

### hdl/ryuv_stream_if.sv
interface ryuv_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/ryuv_raster.sv
module ryuv_raster #(
	parameter int MAX_DIM = ryuv_pkg::DEFAULT_MAX_DIM
) (
	input  logic            clk,
	input  logic            arst_n,
	ryuv_stream_if.sink     cfg,
	input  logic            adv,
	output ryuv_pkg::pos_t  pos
);
	import ryuv_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int LIM_W = ($clog2(MAX_DIM + 1) > CFG_DATA_W) ? $clog2(MAX_DIM + 1) : CFG_DATA_W;

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [CNT_W-1:0]      col_q;
	logic [CNT_W-1:0]      row_q;
	logic [LIM_W-1:0]      width_lim;
	logic [LIM_W-1:0]      height_lim;
	logic [LIM_W-1:0]      col_next;
	logic [LIM_W-1:0]      row_next;
	logic                  last_col;
	logic                  last_row;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DATA_W'(WIDTH_RESET);
			height_q <= CFG_DATA_W'(HEIGHT_RESET);
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_WIDTH:  width_q  <= cfg.data.value;
				REG_HEIGHT: height_q <= cfg.data.value;
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize saturates
	always_comb begin
		if (width_q == '0) begin
			width_lim = LIM_W'(1);
		end else if (LIM_W'(width_q) > LIM_W'(MAX_DIM)) begin
			width_lim = LIM_W'(MAX_DIM);
		end else begin
			width_lim = LIM_W'(width_q);
		end
		if (height_q == '0) begin
			height_lim = LIM_W'(1);
		end else if (LIM_W'(height_q) > LIM_W'(MAX_DIM)) begin
			height_lim = LIM_W'(MAX_DIM);
		end else begin
			height_lim = LIM_W'(height_q);
		end
	end

	assign col_next = LIM_W'(col_q) + LIM_W'(1);
	assign row_next = LIM_W'(row_q) + LIM_W'(1);
	assign last_col = (col_next >= width_lim);
	assign last_row = (row_next >= height_lim);

	always_comb begin
		if (col_q[0]) begin
			pos.chroma_kind = CK_NONE;
		end else if (row_q[0]) begin
			pos.chroma_kind = CK_CR;
		end else begin
			pos.chroma_kind = CK_CB;
		end
		pos.frame_end = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_next[CNT_W-1:0];
			end else begin
				col_q <= col_next[CNT_W-1:0];
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		LIM_W'(col_q) < LIM_W'(MAX_DIM) && LIM_W'(row_q) < LIM_W'(MAX_DIM))
		else $error("raster counter beyond maximum dimension");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && pos.frame_end |=> col_q == '0 && row_q == '0)
		else $error("counters not cleared after frame end");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && !last_col |=> col_q == $past(col_next[CNT_W-1:0]) && row_q == $past(row_q))
		else $error("column step wrong");

endmodule

### hdl/ryuv_csc.sv
module ryuv_csc (
	input  ryuv_pkg::pixel_t       px,
	input  ryuv_pkg::chroma_kind_t kind,
	output logic [7:0]             luma,
	output logic [7:0]             chroma
);
	import ryuv_pkg::*;

	logic [15:0] y_sum;
	logic [15:0] c_pos;
	logic [15:0] c_neg;
	logic [15:0] c_sum;

	assign y_sum = 16'(COEF_Y_R * px.red) + 16'(COEF_Y_G * px.green)
		+ 16'(COEF_Y_B * px.blue) + 16'(ROUND_BIAS);
	assign luma  = y_sum[15:8] + 8'(LUMA_OFFSET);

	always_comb begin
		case (kind)
			CK_CB: begin
				c_pos = 16'(COEF_CB_B * px.blue);
				c_neg = 16'(COEF_CB_R * px.red) + 16'(COEF_CB_G * px.green);
			end
			CK_CR: begin
				c_pos = 16'(COEF_CR_R * px.red);
				c_neg = 16'(COEF_CR_G * px.green) + 16'(COEF_CR_B * px.blue);
			end
			default: begin
				c_pos = '0;
				c_neg = '0;
			end
		endcase
	end

	// lift of 128 after the shift supplies the chroma offset
	assign c_sum  = c_pos + 16'(CHROMA_BIAS) - c_neg;
	assign chroma = (kind == CK_NONE) ? 8'd0 : c_sum[15:8];

endmodule

### hdl/rgb_to_yuv420_subsampler_top.sv
// path: an accepted word passes the input register, then the result register that drives res
// throughput: one pixel per cycle while the result channel is not stalled, an input
// register and a result register in series with the colour conversion between them
// reset: clears valid flags and raster counters, image size returns to 640 x 480
module rgb_to_yuv420_subsampler_top #(
	parameter int MAX_DIM = ryuv_pkg::DEFAULT_MAX_DIM
) (
	input  logic          clk,
	input  logic          arst_n,
	ryuv_stream_if.sink   pix,
	ryuv_stream_if.sink   cfg,
	ryuv_stream_if.source res
);
	import ryuv_pkg::*;

	pos_t       pos;
	logic       adv_s1;
	logic       adv_out;
	logic       accept;
	logic       valid_s1;
	pixel_t     pix_s1;
	pos_t       pos_s1;
	logic [7:0] luma;
	logic [7:0] chroma;
	logic       out_valid_q;
	result_t    res_q;

	assign adv_out   = !out_valid_q || res.ready;
	assign adv_s1    = !valid_s1 || adv_out;
	assign pix.ready = adv_s1;
	assign accept    = pix.valid && adv_s1;

	ryuv_raster #(
		.MAX_DIM(MAX_DIM)
	) u_raster (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (accept),
		.pos    (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pix.valid;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix.data;
			pos_s1 <= pos;
		end
	end

	ryuv_csc u_csc (
		.px     (pix_s1),
		.kind   (pos_s1.chroma_kind),
		.luma   (luma),
		.chroma (chroma)
	);

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			res_q.luma        <= luma;
			res_q.chroma      <= chroma;
			res_q.chroma_kind <= pos_s1.chroma_kind;
			res_q.frame_end   <= pos_s1.frame_end;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_out |=> valid_s1 && $stable(pix_s1) && $stable(pos_s1))
		else $error("input stage word lost under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word not captured");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.luma >= 8'd16 && res_q.luma <= 8'd235)
		else $error("luma out of studio range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.chroma_kind != CK_NONE
		|-> res_q.chroma >= 8'd16 && res_q.chroma <= 8'd240)
		else $error("chroma out of studio range");

endmodule
